>>> hdl/ptal_pkg.sv
// ptal_pkg: shared types and constants for the page table aging core
// holds request, result and internal command formats plus operation codes
// no dependencies
`timescale 1ns / 1ps

package ptal_pkg;

    // field widths
    localparam int OP_W    = 3;
    localparam int PAGE_W  = 8;
    localparam int FRAME_W = 6;
    localparam int AGE_W   = 8;

    // highest physical frame number plus one
    localparam int unsigned NUM_FRAMES = 64;

    // operation codes as seen on the request port
    localparam logic [OP_W-1:0] OP_LOOKUP     = 3'd0;
    localparam logic [OP_W-1:0] OP_MAP        = 3'd1;
    localparam logic [OP_W-1:0] OP_INVALIDATE = 3'd2;
    localparam logic [OP_W-1:0] OP_MARK_REF   = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK       = 3'd4;

    // command kinds after classification
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_NULL   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MAP    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INVAL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MARK   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd5;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } request_t;

    typedef struct packed {
        logic               present;
        logic [FRAME_W-1:0] frame_out;
        logic [AGE_W-1:0]   age;
    } result_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } cmd_t;

endpackage

>>> hdl/page_table_aging_lru.sv
// page_table_aging_lru_core: top level of the page table with 8-bit aging
// depends on ptal_pkg, ptal_front, ptal_queue and ptal_back
//
//  channel   signals                    handshake
//  --------  -------------------------  ---------------------------------------
//  request   start, busy, request       item taken at clk edge with start && !busy
//  result    done, result               one-cycle strobe, receiver cannot stall
//
// lookup, map, invalidate and mark referenced go through the back end in order
// (memory read, then execute); an ignored item is answered without a memory read
// an aging tick runs pop, a sweep of one entry of the age memory a cycle,
// the last writeback, then the result
// DEPTH = min(NUM_PAGES, 256); a 2-entry queue lets requests land while the back end works
// busy rises only when the queue is full; reset clears valid and reference bits at once
`timescale 1ns / 1ps

module page_table_aging_lru_core #(
    parameter int unsigned NUM_PAGES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ptal_pkg::request_t request,
    output logic               done,
    output ptal_pkg::result_t  result
);
    import ptal_pkg::*;

    // only pages reachable through the page field get storage
    localparam int unsigned PAGE_SPAN = 2 ** PAGE_W;
    localparam int unsigned DEPTH = (NUM_PAGES < PAGE_SPAN) ? NUM_PAGES : PAGE_SPAN;

    logic push;
    logic q_full;
    logic q_empty;
    logic pop;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // classify incoming items
    ptal_front #(
        .NUM_PAGES(NUM_PAGES)
    ) u_front (
        .start  (start),
        .request(request),
        .q_full (q_full),
        .busy   (busy),
        .push   (push),
        .cmd    (push_cmd)
    );

    // decouple front and back
    ptal_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_data (head_cmd),
        .empty    (q_empty)
    );

    // table storage and execution
    ptal_back #(
        .DEPTH(DEPTH)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (q_empty),
        .head  (head_cmd),
        .pop   (pop),
        .done  (done),
        .result(result)
    );

endmodule

>>> hdl/ptal_front.sv
// ptal_front: accepts request items and classifies them into commands
// depends on ptal_pkg; pushes into ptal_queue
`timescale 1ns / 1ps

module ptal_front #(
    parameter int unsigned NUM_PAGES = 256
) (
    input  logic              start,
    input  ptal_pkg::request_t request,
    input  logic              q_full,
    output logic              busy,
    output logic              push,
    output ptal_pkg::cmd_t    cmd
);
    import ptal_pkg::*;

    logic page_ok;
    logic frame_ok;

    // range checks against table and frame limits
    assign page_ok  = 32'(request.page) < NUM_PAGES;
    assign frame_ok = 32'(request.frame) < NUM_FRAMES;

    // item accepted only while the queue has room
    assign busy = q_full;
    assign push = start && !q_full;

    // classify the item
    always_comb
    begin
        cmd.page  = request.page;
        cmd.frame = request.frame;
        case (request.operation)
            OP_TICK:       cmd.kind = KIND_TICK;
            OP_LOOKUP:     cmd.kind = page_ok ? KIND_LOOKUP : KIND_NULL;
            // out-of-range frame leaves the entry alone and just reports it
            OP_MAP:        cmd.kind = !page_ok ? KIND_NULL :
                                      (frame_ok ? KIND_MAP : KIND_LOOKUP);
            OP_INVALIDATE: cmd.kind = page_ok ? KIND_INVAL : KIND_NULL;
            OP_MARK_REF:   cmd.kind = page_ok ? KIND_MARK : KIND_NULL;
            default:       cmd.kind = KIND_NULL;
        endcase
    end

endmodule

>>> hdl/ptal_queue.sv
// ptal_queue: short command fifo between front and back
// depends on ptal_pkg for cmd_t and queue depth
`timescale 1ns / 1ps

module ptal_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ptal_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output ptal_pkg::cmd_t pop_data,
    output logic           empty
);
    import ptal_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/ptal_back.sv
// ptal_back: page table storage and command execution, including the aging sweep
// depends on ptal_pkg; takes commands from ptal_queue
`timescale 1ns / 1ps

module ptal_back #(
    parameter int unsigned DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  ptal_pkg::cmd_t    head,
    output logic              pop,
    output logic              done,
    output ptal_pkg::result_t result
);
    import ptal_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W:0] CNT_END = (IDX_W + 1)'(DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    logic [1:0]       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [IDX_W:0]   cnt_reg, cnt_next;
    logic             wb_vld_reg, wb_vld_next;
    logic [IDX_W-1:0] wb_idx_reg, wb_idx_next;
    logic             done_reg, done_next;
    result_t          res_reg, res_next;
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [DEPTH-1:0] ref_reg, ref_next;

    // memory ports
    logic [AGE_W-1:0]   age_mem [DEPTH];
    logic [FRAME_W-1:0] frame_mem [DEPTH];
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               age_we;
    logic [IDX_W-1:0]   age_wa;
    logic [AGE_W-1:0]   age_wd;
    logic               frame_we;
    logic [AGE_W-1:0]   age_q;
    logic [FRAME_W-1:0] frame_q;

    logic [IDX_W-1:0] exec_idx;
    logic             exec_valid;

    assign exec_idx   = cmd_reg.page[IDX_W-1:0];
    assign exec_valid = valid_reg[exec_idx];

    assign done   = done_reg;
    assign result = res_reg;

    // command sequencer
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        cnt_next    = cnt_reg;
        wb_vld_next = 1'b0;
        wb_idx_next = wb_idx_reg;
        done_next   = 1'b0;
        res_next    = '0;
        valid_next  = valid_reg;
        ref_next    = ref_reg;
        pop         = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = exec_idx;
        age_we      = 1'b0;
        age_wa      = exec_idx;
        age_wd      = '0;
        frame_we    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    case (head.kind)
                        KIND_TICK:
                        begin
                            state_next = ST_SWEEP;
                            cnt_next   = '0;
                        end
                        KIND_LOOKUP, KIND_MAP, KIND_INVAL, KIND_MARK:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head.page[IDX_W-1:0];
                            state_next = ST_EXEC;
                        end
                        default:
                        begin
                            // ignored item still yields an all-zero result
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                case (cmd_reg.kind)
                    KIND_MAP:
                    begin
                        frame_we             = 1'b1;
                        age_we               = 1'b1;
                        valid_next[exec_idx] = 1'b1;
                        ref_next[exec_idx]   = 1'b0;
                        res_next.present     = 1'b1;
                        res_next.frame_out   = cmd_reg.frame;
                    end
                    KIND_INVAL:
                    begin
                        // invalid entries read back as zero age and frame
                        valid_next[exec_idx] = 1'b0;
                        ref_next[exec_idx]   = 1'b0;
                    end
                    KIND_MARK:
                    begin
                        ref_next[exec_idx] = 1'b1;
                        res_next.present   = exec_valid;
                        res_next.frame_out = exec_valid ? frame_q : '0;
                        res_next.age       = exec_valid ? age_q : '0;
                    end
                    default:
                    begin
                        res_next.present   = exec_valid;
                        res_next.frame_out = exec_valid ? frame_q : '0;
                        res_next.age       = exec_valid ? age_q : '0;
                    end
                endcase
            end
            ST_SWEEP:
            begin
                // read one entry a cycle
                if (cnt_reg < CNT_END)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = cnt_reg[IDX_W-1:0];
                    wb_vld_next = 1'b1;
                    wb_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next    = cnt_reg + 1'b1;
                end
                // write back the entry read in the previous cycle
                if (wb_vld_reg && valid_reg[wb_idx_reg])
                begin
                    age_we               = 1'b1;
                    age_wa               = wb_idx_reg;
                    age_wd               = {ref_reg[wb_idx_reg], age_q[AGE_W-1:1]};
                    ref_next[wb_idx_reg] = 1'b0;
                end
                if (cnt_reg == CNT_END && !wb_vld_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            wb_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
            valid_reg  <= '0;
            ref_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            wb_vld_reg <= wb_vld_next;
            done_reg   <= done_next;
            valid_reg  <= valid_next;
            ref_reg    <= ref_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        wb_idx_reg <= wb_idx_next;
        res_reg    <= res_next;
    end

    // age memory, registered read
    always_ff @(posedge clk)
    begin
        if (age_we)
        begin
            age_mem[age_wa] <= age_wd;
        end
        if (rd_en)
        begin
            age_q <= age_mem[rd_addr];
        end
    end

    // frame memory, registered read
    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[exec_idx] <= cmd_reg.frame;
        end
        if (rd_en)
        begin
            frame_q <= frame_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    // commands leave the queue only between commands
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == ST_IDLE)
        else $error("command popped while back end busy");

    // every executed command yields exactly one result next cycle
    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |=> done_reg)
        else $error("executed command produced no result");

    // a map reports a present page with a fresh age
    a_map_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && cmd_reg.kind == KIND_MAP)
        |=> (res_reg.present && res_reg.age == '0))
        else $error("map result not present with zero age");

    // absent pages report zero frame and age
    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !res_reg.present) |-> (res_reg.frame_out == '0 && res_reg.age == '0))
        else $error("absent page reported nonzero fields");

    // sweep writebacks only follow a sweep read
    a_sweep_wb: assert property (@(posedge clk) disable iff (!rst_n)
        wb_vld_reg |-> $past(state_reg == ST_SWEEP))
        else $error("sweep writeback outside a sweep");
`endif

endmodule

>>> tb/page_table_aging_lru_core_test.sv
// page_table_aging_lru_core_test: self-checking bench for the page table aging core
// directed table then weighted random items, each result checked against a fixed value or a local model
// depends on ptal_pkg and page_table_aging_lru_core
`timescale 1ns / 1ps

module page_table_aging_lru_core_test;

    import ptal_pkg::*;

    localparam int unsigned PAGES      = 256;
    localparam int          N_DIRECTED = 25;
    localparam int          N_RANDOM   = 1250;
    localparam int          N_CALM     = 150;
    localparam int          DRAIN_MAX  = 4000;
    localparam int          TAIL_WAIT  = 300;

    // op codes the block does not define
    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    localparam logic [AGE_W-1:0] AGE_MSB = 8'h80;

    typedef struct {
        bit      typed;
        result_t want;
    } fixed_result_t;

    typedef struct {
        request_t      req;
        fixed_result_t fixed;
    } dir_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t req_item;
    logic     done;
    result_t  res_item;

    // local copy of the page table
    bit [FRAME_W-1:0] pt_frame [PAGES];
    bit               pt_valid [PAGES];
    bit               pt_ref   [PAGES];
    bit [AGE_W-1:0]   pt_age   [PAGES];

    result_t       pending_results [$];
    fixed_result_t fixed_results   [$];
    int unsigned   taken_cnt;
    int unsigned   fail_cnt;

    dir_row_t dir_rows [N_DIRECTED];

    page_table_aging_lru_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (req_item),
        .done    (done),
        .result  (res_item)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // apply one item to the page table copy and return its result
    function automatic result_t page_table_step(request_t req);
        result_t     res;
        int unsigned p;
        bit          addressed;
        res       = '0;
        p         = 32'(req.page);
        addressed = 1'b1;
        case (req.operation)
            OP_LOOKUP:
            begin
            end
            OP_MAP:
            begin
                if (req.frame < NUM_FRAMES)
                begin
                    pt_frame[p] = req.frame;
                    pt_valid[p] = 1'b1;
                    pt_ref[p]   = 1'b0;
                    pt_age[p]   = '0;
                end
            end
            OP_INVALIDATE:
            begin
                pt_frame[p] = '0;
                pt_valid[p] = 1'b0;
                pt_ref[p]   = 1'b0;
                pt_age[p]   = '0;
            end
            OP_MARK_REF:
            begin
                pt_ref[p] = 1'b1;
            end
            OP_TICK:
            begin
                // sweep valid entries: shift in the reference bit at the top
                for (int i = 0; i < PAGES; i++)
                begin
                    if (pt_valid[i])
                    begin
                        pt_age[i] = (pt_age[i] >> 1) | (pt_ref[i] ? AGE_MSB : 8'h00);
                        pt_ref[i] = 1'b0;
                    end
                end
                addressed = 1'b0;
            end
            default:
            begin
                addressed = 1'b0;
            end
        endcase
        if (addressed)
        begin
            res.present   = pt_valid[p];
            res.frame_out = pt_valid[p] ? pt_frame[p] : '0;
            res.age       = pt_age[p];
        end
        return res;
    endfunction

    function automatic dir_row_t row(logic [OP_W-1:0] op, int unsigned pg, int unsigned fr,
                                     int unsigned typed, int unsigned pres, int unsigned fo,
                                     int unsigned ag);
        dir_row_t r;
        r.req.operation     = op;
        r.req.page          = PAGE_W'(pg);
        r.req.frame         = FRAME_W'(fr);
        r.fixed.typed       = (typed != 0);
        r.fixed.want.present   = (pres != 0);
        r.fixed.want.frame_out = FRAME_W'(fo);
        r.fixed.want.age       = AGE_W'(ag);
        return r;
    endfunction

    // weighted random item, mostly on a few hot pages so entries get reused
    function automatic request_t random_request();
        request_t    req;
        int unsigned sel;
        int unsigned psel;
        sel  = $urandom_range(0, 99);
        psel = $urandom_range(0, 9);
        if (sel < 30)
            req.operation = OP_LOOKUP;
        else if (sel < 52)
            req.operation = OP_MAP;
        else if (sel < 62)
            req.operation = OP_INVALIDATE;
        else if (sel < 88)
            req.operation = OP_MARK_REF;
        else if (sel < 94)
            req.operation = OP_TICK;
        else if (sel < 96)
            req.operation = OP_RSVD_5;
        else if (sel < 98)
            req.operation = OP_RSVD_6;
        else
            req.operation = OP_RSVD_7;
        if (psel < 6)
            req.page = PAGE_W'($urandom_range(0, 15));
        else if (psel == 6)
            req.page = PAGE_W'($urandom_range(PAGES - 4, PAGES - 1));
        else
            req.page = PAGE_W'($urandom_range(0, PAGES - 1));
        req.frame = FRAME_W'($urandom_range(0, NUM_FRAMES - 1));
        return req;
    endfunction

    // offer one item at a falling edge and hold it until taken
    task automatic send_item(request_t req, fixed_result_t fixed);
        int unsigned seen;
        seen = taken_cnt;
        fixed_results.push_back(fixed);
        start    <= 1'b1;
        req_item <= req;
        do
            @(negedge clk);
        while (taken_cnt == seen);
    endtask

    // drop start for an idle burst of random length
    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
    endtask

    // hold off until every expected result has come back
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    // result checker and expectation capture on the rising edge
    always @(posedge clk)
    begin : monitor
        result_t       want;
        fixed_result_t fixed;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with nothing expected: present %0d frame_out %0d age %0d",
                           res_item.present, res_item.frame_out, res_item.age);
                    fail_cnt++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (res_item.present !== want.present)
                    begin
                        $error("present: expected %0d, got %0d", want.present, res_item.present);
                        fail_cnt++;
                    end
                    if (res_item.frame_out !== want.frame_out)
                    begin
                        $error("frame_out: expected %0d, got %0d",
                               want.frame_out, res_item.frame_out);
                        fail_cnt++;
                    end
                    if (res_item.age !== want.age)
                    begin
                        $error("age: expected 0x%02h, got 0x%02h", want.age, res_item.age);
                        fail_cnt++;
                    end
                end
            end
            if (start && !busy)
            begin
                fixed = fixed_results.pop_front();
                want  = page_table_step(req_item);
                if (fixed.typed)
                    want = fixed.want;
                pending_results.push_back(want);
                taken_cnt++;
            end
        end
    end

    // watchdog
    initial
    begin
        #100_000_000;
        $display("FAIL");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        fixed_result_t no_fixed;
        int            drain_cycles;
        no_fixed = '{typed: 1'b0, want: '0};
        rst_n     = 1'b0;
        start     = 1'b0;
        req_item  = '0;
        taken_cnt = 0;
        fail_cnt  = 0;

        // directed table: extremes, every op, reserved ops, corner cases
        dir_rows = '{
            row(OP_LOOKUP,     0,   0,  1, 0, 0,  0),  // empty table after reset
            row(OP_LOOKUP,     255, 63, 1, 0, 0,  0),
            row(OP_MAP,        0,   63, 1, 1, 63, 0),
            row(OP_MAP,        255, 0,  1, 1, 0,  0),
            row(OP_MARK_REF,   0,   0,  1, 1, 63, 0),
            row(OP_TICK,       0,   0,  1, 0, 0,  0),
            row(OP_LOOKUP,     0,   0,  0, 0, 0,  0),
            row(OP_MARK_REF,   10,  0,  1, 0, 0,  0),  // reference on invalid page
            row(OP_TICK,       255, 63, 1, 0, 0,  0),  // page field ignored by tick
            row(OP_LOOKUP,     10,  0,  1, 0, 0,  0),
            row(OP_RSVD_5,     0,   0,  1, 0, 0,  0),
            row(OP_RSVD_6,     255, 63, 1, 0, 0,  0),
            row(OP_RSVD_7,     0,   0,  1, 0, 0,  0),
            row(OP_LOOKUP,     0,   0,  0, 0, 0,  0),
            row(OP_MARK_REF,   255, 0,  0, 0, 0,  0),
            row(OP_TICK,       0,   0,  1, 0, 0,  0),
            row(OP_LOOKUP,     255, 0,  0, 0, 0,  0),
            row(OP_INVALIDATE, 0,   0,  1, 0, 0,  0),
            row(OP_LOOKUP,     0,   0,  1, 0, 0,  0),
            row(OP_INVALIDATE, 7,   0,  1, 0, 0,  0),  // never mapped
            row(OP_MAP,        42,  42, 1, 1, 42, 0),
            row(OP_MAP,        42,  21, 1, 1, 21, 0),  // remap
            row(OP_MARK_REF,   42,  0,  0, 0, 0,  0),
            row(OP_MAP,        42,  5,  1, 1, 5,  0),  // map drops the reference
            row(OP_TICK,       0,   0,  1, 0, 0,  0)
        };

        // hold reset, then release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        foreach (dir_rows[i])
        begin
            if ($urandom_range(0, 3) == 0)
                idle_burst();
            send_item(dir_rows[i].req, dir_rows[i].fixed);
        end
        wait_drained();

        // random part, calm at the end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n < N_RANDOM - N_CALM)
            begin
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
                else if ($urandom_range(0, 3) == 0)
                    idle_burst();
            end
            send_item(random_request(), no_fixed);
        end
        start <= 1'b0;

        // drain outstanding results
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < DRAIN_MAX)
        begin
            @(negedge clk);
            drain_cycles++;
        end
        repeat (TAIL_WAIT) @(negedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_cnt++;
        end

        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> page_table_aging_lru_core.f
hdl/ptal_pkg.sv
hdl/ptal_front.sv
hdl/ptal_queue.sv
hdl/ptal_back.sv
hdl/page_table_aging_lru.sv
tb/page_table_aging_lru_core_test.sv
